FILE: hdl/skmm_pkg.sv
// Shared types and constants for the string key table with multiple-match search.
`default_nettype none

package skmm_pkg;

   // Word geometry: 30 characters of 8 bits, first character in the low byte
   localparam int WORD_CHARS = 30;
   localparam int WORD_W     = WORD_CHARS * 8;
   localparam int SLOT_W     = 4;

   // Search returns at most this many matches
   localparam int MAX_RESULTS = 16;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   // Request function codes
   localparam logic [1:0] FN_INSERT = 2'd0;
   localparam logic [1:0] FN_DELETE = 2'd1;
   localparam logic [1:0] FN_SEARCH = 2'd2;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_INSERTED  = 3'd0,
      STAT_FULL      = 3'd1,
      STAT_DELETED   = 3'd2,
      STAT_BAD_INDEX = 3'd3,
      STAT_MATCH     = 3'd4,
      STAT_NOT_FOUND = 3'd5
   } status_type;

   // Request payload
   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key_chars_0_7;
      logic [63:0] key_chars_8_15;
      logic [63:0] key_chars_16_23;
      logic [47:0] key_chars_24_29;
      logic [63:0] val_chars_0_7;
      logic [63:0] val_chars_8_15;
      logic [63:0] val_chars_16_23;
      logic [47:0] val_chars_24_29;
      logic [3:0]  delete_slot;
   } req_type;

   // Result payload
   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic [63:0] out_chars_0_7;
      logic [63:0] out_chars_8_15;
      logic [63:0] out_chars_16_23;
      logic [47:0] out_chars_24_29;
      logic        last;
   } rsp_type;

endpackage

`default_nettype wire

FILE: hdl/string_key_table_multi_match_core.sv
// A delete gives its result in the cycle after the request; an insert checks one valid
// bit per cycle up to the high-water count; a search reads one key RAM entry per cycle
// and gives its last result after the last entry, or once MAX_RESULTS matches are found.
// One request at a time; insert and search hold busy until their last result is driven,
// a delete never raises busy and a new request may follow at once.
// Results are one-cycle strobes and cannot be stalled. Reset empties the table at once.
`default_nettype none

module string_key_table_multi_match_core #(
   parameter int ENTRIES = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire skmm_pkg::req_type req_data,
   output logic                  busy,
   output logic                  rsp_valid,
   output skmm_pkg::rsp_type     rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_INSERT = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_FLUSH  = 4'b1000
   } state_type;

   state_type                    state_ff, state_in;
   logic [ENTRIES-1:0]           valid_ff, valid_in;
   logic [CNT_W-1:0]             hw_ff, hw_in;
   logic [CNT_W-1:0]             scan_ff, scan_in;
   logic                         issue_on_ff, issue_on_in;
   logic                         rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                         pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]             pend_idx_ff, pend_idx_in;
   logic [skmm_pkg::WORD_W-1:0]  pend_val_ff, pend_val_in;
   logic [skmm_pkg::RES_W-1:0]   hits_ff, hits_in;
   logic [skmm_pkg::WORD_W-1:0]  key_ff, key_in;
   logic [skmm_pkg::WORD_W-1:0]  val_ff, val_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   skmm_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic [skmm_pkg::WORD_W-1:0]  req_key_raw, req_val_raw;
   logic [skmm_pkg::WORD_W-1:0]  req_key_norm, req_val_norm;
   logic [skmm_pkg::WORD_W-1:0]  key_rd, val_rd;
   logic [IDX_W-1:0]             scan_idx;
   logic [IDX_W-1:0]             del_idx;
   logic                         del_bad;
   logic                         ram_we;
   logic                         hit;

   // Build a result from status, slot, value word and last flag
   function automatic skmm_pkg::rsp_type mk_rsp(
      input skmm_pkg::status_type   status,
      input logic [3:0]             slot,
      input logic [skmm_pkg::WORD_W-1:0] word,
      input logic                   last
   );
      skmm_pkg::rsp_type r;
      r.status          = status;
      r.slot            = slot;
      r.out_chars_0_7   = word[63:0];
      r.out_chars_8_15  = word[127:64];
      r.out_chars_16_23 = word[191:128];
      r.out_chars_24_29 = word[239:192];
      r.last            = last;
      return r;
   endfunction

   // Request words, first character in the low byte
   assign req_key_raw = {req_data.key_chars_24_29, req_data.key_chars_16_23,
                         req_data.key_chars_8_15, req_data.key_chars_0_7};
   assign req_val_raw = {req_data.val_chars_24_29, req_data.val_chars_16_23,
                         req_data.val_chars_8_15, req_data.val_chars_0_7};

   skmm_norm u_key_norm (
      .word_in  (req_key_raw),
      .word_out (req_key_norm)
   );

   skmm_norm u_val_norm (
      .word_in  (req_val_raw),
      .word_out (req_val_norm)
   );

   assign scan_idx = scan_ff[IDX_W-1:0];
   assign del_idx  = IDX_W'(req_data.delete_slot);
   assign del_bad  = 32'(req_data.delete_slot) >= 32'(hw_ff);

   // Key and value stores share one address: scan pointer
   skmm_ram #(
      .WIDTH (skmm_pkg::WORD_W),
      .DEPTH (ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (scan_idx),
      .wr_data (key_ff),
      .rd_addr (scan_idx),
      .rd_data (key_rd)
   );

   skmm_ram #(
      .WIDTH (skmm_pkg::WORD_W),
      .DEPTH (ENTRIES)
   ) u_val_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (scan_idx),
      .wr_data (val_ff),
      .rd_addr (scan_idx),
      .rd_data (val_rd)
   );

   // Compare stage: entry read last cycle is valid and its key matches
   assign hit = rd_vld_ff && valid_ff[rd_idx_ff] && (key_rd == key_ff);

   // Control and datapath next state
   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      hw_in        = hw_ff;
      scan_in      = scan_ff;
      issue_on_in  = issue_on_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      pend_val_in  = pend_val_ff;
      hits_in      = hits_ff;
      key_in       = key_ff;
      val_in       = val_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in = req_key_norm;
               val_in = req_val_norm;
               case (req_data.func)
                  skmm_pkg::FN_INSERT: begin
                     scan_in  = '0;
                     state_in = ST_INSERT;
                  end
                  skmm_pkg::FN_DELETE: begin
                     rsp_valid_in = 1'b1;
                     if (del_bad) begin
                        rsp_data_in = mk_rsp(skmm_pkg::STAT_BAD_INDEX, req_data.delete_slot,
                                             '0, 1'b1);
                     end else begin
                        valid_in[del_idx] = 1'b0;
                        rsp_data_in = mk_rsp(skmm_pkg::STAT_DELETED, req_data.delete_slot,
                                             '0, 1'b1);
                     end
                  end
                  skmm_pkg::FN_SEARCH: begin
                     scan_in     = '0;
                     issue_on_in = 1'b1;
                     pend_vld_in = 1'b0;
                     hits_in     = '0;
                     state_in    = ST_SEARCH;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Walk valid bits up to the high-water count for the first free slot
         ST_INSERT: begin
            if (scan_ff == hw_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (hw_ff == CNT_W'(ENTRIES)) begin
                  rsp_data_in = mk_rsp(skmm_pkg::STAT_FULL, 4'd0, '0, 1'b1);
               end else begin
                  ram_we             = 1'b1;
                  valid_in[scan_idx] = 1'b1;
                  hw_in              = hw_ff + CNT_W'(1);
                  rsp_data_in = mk_rsp(skmm_pkg::STAT_INSERTED,
                                       skmm_pkg::SLOT_W'(scan_ff), '0, 1'b1);
               end
            end else if (!valid_ff[scan_idx]) begin
               ram_we             = 1'b1;
               valid_in[scan_idx] = 1'b1;
               rsp_valid_in       = 1'b1;
               rsp_data_in  = mk_rsp(skmm_pkg::STAT_INSERTED,
                                     skmm_pkg::SLOT_W'(scan_ff), '0, 1'b1);
               state_in     = ST_IDLE;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end

         // Read one entry per cycle; hold back one match to place the last flag
         ST_SEARCH: begin
            if (issue_on_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = scan_idx;
               scan_in   = scan_ff + CNT_W'(1);
               if (scan_ff == CNT_W'(ENTRIES - 1)) begin
                  issue_on_in = 1'b0;
               end
            end
            if (hit) begin
               if (pend_vld_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mk_rsp(skmm_pkg::STAT_MATCH,
                                        skmm_pkg::SLOT_W'(pend_idx_ff), pend_val_ff, 1'b0);
               end
               pend_vld_in = 1'b1;
               pend_idx_in = rd_idx_ff;
               pend_val_in = val_rd;
               hits_in     = hits_ff + skmm_pkg::RES_W'(1);
            end
            if ((hit && hits_ff == skmm_pkg::RES_W'(skmm_pkg::MAX_RESULTS - 1)) ||
                !issue_on_ff) begin
               state_in = ST_FLUSH;
            end
         end

         // Final result of a search
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
            if (pend_vld_ff) begin
               rsp_data_in = mk_rsp(skmm_pkg::STAT_MATCH,
                                    skmm_pkg::SLOT_W'(pend_idx_ff), pend_val_ff, 1'b1);
            end else begin
               rsp_data_in = mk_rsp(skmm_pkg::STAT_NOT_FOUND, 4'd0, '0, 1'b1);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         hw_ff        <= '0;
         issue_on_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         hits_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         hw_ff        <= hw_in;
         issue_on_ff  <= issue_on_in;
         rd_vld_ff    <= rd_vld_in;
         pend_vld_ff  <= pend_vld_in;
         hits_ff      <= hits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      rd_idx_ff   <= rd_idx_in;
      pend_idx_ff <= pend_idx_in;
      pend_val_ff <= pend_val_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: hdl/skmm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module skmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: hdl/skmm_norm.sv
// Word normalizer: clears every character after the first zero character.
`default_nettype none

module skmm_norm (
   input  wire logic [skmm_pkg::WORD_W-1:0] word_in,
   output logic      [skmm_pkg::WORD_W-1:0] word_out
);

   logic [skmm_pkg::WORD_CHARS-1:0] ended;

   // Running "terminator seen" flag, one bit per character
   always_comb begin
      for (int i = 0; i < skmm_pkg::WORD_CHARS; i++) begin
         if (i == 0) begin
            ended[i] = (word_in[7:0] == 8'd0);
         end else begin
            ended[i] = ended[i-1] | (word_in[i*8 +: 8] == 8'd0);
         end
         word_out[i*8 +: 8] = ended[i] ? 8'd0 : word_in[i*8 +: 8];
      end
   end

endmodule

`default_nettype wire
